@@ rtl/core/pls_pkg.sv @@
// Package for the particle life step block: widths, register indexes and
// the flat types shared by the interfaces and the core. No dependencies.
package pls_pkg;

    localparam int FracBitsDefault = 16;
    localparam int ProgBits = 25;
    localparam int DivNumBits = ProgBits + 31;

    typedef enum logic [1:0] {
        REG_GRAVITY = 2'd0,
        REG_GRAVITY_EFFECT = 2'd1,
        REG_ATLAS_ROWS = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic signed [31:0] position_z;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic signed [31:0] velocity_z;
        logic signed [31:0] life_left;
        logic [30:0] life_total;
        logic signed [31:0] camera_x;
        logic signed [31:0] camera_y;
        logic signed [31:0] camera_z;
        logic [30:0] frame_time;
    } particle_in_t;

    typedef struct packed {
        logic alive;
        logic signed [31:0] new_position_x;
        logic signed [31:0] new_position_y;
        logic signed [31:0] new_position_z;
        logic signed [31:0] new_velocity_y;
        logic signed [31:0] new_life_left;
        logic signed [31:0] camera_distance_sq;
        logic [8:0] atlas_frame;
        logic [8:0] atlas_next_frame;
        logic [15:0] frame_blend;
    } particle_out_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -68'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

@@ rtl/core/pls_if.sv @@
// Valid/ready channel carrying one particle beat of a payload type.
// Depends on pls_pkg for the payload structs.
interface pls_in_if
    import pls_pkg::*;
();
    logic valid;
    logic ready;
    particle_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pls_out_if
    import pls_pkg::*;
();
    logic valid;
    logic ready;
    particle_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/particle_life_step_top.sv @@
// Top level of the particle life step: configuration registers, the physics
// pipeline and the atlas divider. Depends on pls_pkg, pls_if and pls_divider.
//
// One particle beat is accepted every cycle unless the output stalls: six stages
// of physics, distance and atlas numerator arithmetic feed a divider of 26
// registers that produces the atlas progression one bit per stage, followed by
// a final output register. The whole pipeline advances when the output register
// is empty or taken, so a stall holds every stage.
module particle_life_step_top
    import pls_pkg::*;
#(
    parameter int FractionBits = FracBitsDefault
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data,
    pls_in_if.sink in_ch,
    pls_out_if.source out_ch
);
    typedef enum logic [1:0] {
        PM_ZERO = 2'd0,
        PM_FULL = 2'd1,
        PM_DIV = 2'd2,
        PM_DEAD = 2'd3
    } prog_mode_t;

    localparam int SideBits = $bits(particle_out_t) + 2;

    logic signed [31:0] gravity_reg;
    logic signed [31:0] gravity_effect_reg;
    logic [4:0] atlas_rows_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            gravity_reg <= -32'sd642252;
            gravity_effect_reg <= 32'sd65536;
            atlas_rows_reg <= 5'd1;
        end
        else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_GRAVITY: gravity_reg <= cfg_data;
                REG_GRAVITY_EFFECT: gravity_effect_reg <= cfg_data;
                REG_ATLAS_ROWS: atlas_rows_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Gravity times effect is registered from the configuration registers, so it settles the cycle after a write.
    logic signed [63:0] ge_prod;
    logic signed [31:0] accel_reg;
    logic [8:0] frames_reg;
    logic [4:0] rows_c;
    assign ge_prod = gravity_reg * gravity_effect_reg;
    always_comb begin
        rows_c = atlas_rows_reg;
        if (rows_c == 5'd0) begin
            rows_c = 5'd1;
        end
        if (rows_c > 5'd16) begin
            rows_c = 5'd16;
        end
    end
    always_ff @(posedge clk) begin
        accel_reg <= sat32(68'(ge_prod >>> FractionBits));
        frames_reg <= 9'(rows_c) * 9'(rows_c);
    end

    logic en;
    logic out_v_reg;
    particle_out_t out_reg;
    particle_out_t out_next;
    assign en = !out_v_reg || out_ch.ready;
    assign in_ch.ready = en;

    // Stage 1: differences and new life.
    particle_in_t p1_reg;
    logic v1_reg;
    logic signed [32:0] life1_reg;
    logic signed [32:0] dx1_reg, dy1_reg, dz1_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
        end
        else if (en) begin
            v1_reg <= in_ch.valid;
        end
    end
    always_ff @(posedge clk) begin
        if (en) begin
            p1_reg <= in_ch.data;
            life1_reg <= 33'(in_ch.data.life_left) - 33'(signed'({1'b0, in_ch.data.frame_time}));
            dx1_reg <= 33'(in_ch.data.camera_x) - 33'(in_ch.data.position_x);
            dy1_reg <= 33'(in_ch.data.camera_y) - 33'(in_ch.data.position_y);
            dz1_reg <= 33'(in_ch.data.camera_z) - 33'(in_ch.data.position_z);
        end
    end

    // Stage 2: squares and velocity products.
    particle_in_t p2_reg;
    logic v2_reg;
    logic signed [32:0] life2_reg;
    logic [65:0] sqx_reg, sqy_reg, sqz_reg;
    logic signed [63:0] mx_reg, mz_reg, ma_reg;
    logic [32:0] ax, ay, az;
    assign ax = dx1_reg[32] ? 33'(-dx1_reg) : 33'(dx1_reg);
    assign ay = dy1_reg[32] ? 33'(-dy1_reg) : 33'(dy1_reg);
    assign az = dz1_reg[32] ? 33'(-dz1_reg) : 33'(dz1_reg);
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v2_reg <= 1'b0;
        end
        else if (en) begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge clk) begin
        if (en) begin
            p2_reg <= p1_reg;
            life2_reg <= life1_reg;
            sqx_reg <= ax * ax;
            sqy_reg <= ay * ay;
            sqz_reg <= az * az;
            mx_reg <= p1_reg.velocity_x * signed'({1'b0, p1_reg.frame_time});
            mz_reg <= p1_reg.velocity_z * signed'({1'b0, p1_reg.frame_time});
            ma_reg <= accel_reg * signed'({1'b0, p1_reg.frame_time});
        end
    end

    // Stage 3: new velocity, x and z, distance sum.
    particle_in_t p3_reg;
    logic v3_reg;
    logic signed [32:0] life3_reg;
    logic signed [31:0] nvy3_reg, nx3_reg, nz3_reg, dist3_reg;
    logic [67:0] dsum;
    assign dsum = 68'(sqx_reg) + 68'(sqy_reg) + 68'(sqz_reg);
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v3_reg <= 1'b0;
        end
        else if (en) begin
            v3_reg <= v2_reg;
        end
    end
    always_ff @(posedge clk) begin
        if (en) begin
            p3_reg <= p2_reg;
            life3_reg <= life2_reg;
            nvy3_reg <= sat32(68'(p2_reg.velocity_y) + 68'(ma_reg >>> FractionBits));
            nx3_reg <= sat32(68'(p2_reg.position_x) + 68'(mx_reg >>> FractionBits));
            nz3_reg <= sat32(68'(p2_reg.position_z) + 68'(mz_reg >>> FractionBits));
            if ((dsum >> FractionBits) > 68'd2147483647) begin
                dist3_reg <= 32'sh7fffffff;
            end
            else begin
                dist3_reg <= 32'(dsum >> FractionBits);
            end
        end
    end

    // Stage 4: y product.
    particle_in_t p4_reg;
    logic v4_reg;
    logic signed [32:0] life4_reg;
    logic signed [31:0] nvy4_reg, nx4_reg, nz4_reg, dist4_reg;
    logic signed [63:0] my_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v4_reg <= 1'b0;
        end
        else if (en) begin
            v4_reg <= v3_reg;
        end
    end
    always_ff @(posedge clk) begin
        if (en) begin
            p4_reg <= p3_reg;
            life4_reg <= life3_reg;
            nvy4_reg <= nvy3_reg;
            nx4_reg <= nx3_reg;
            nz4_reg <= nz3_reg;
            dist4_reg <= dist3_reg;
            my_reg <= nvy3_reg * signed'({1'b0, p3_reg.frame_time});
        end
    end

    // Stage 5: result assembly except the atlas fields.
    particle_out_t r5_reg;
    logic v5_reg;
    prog_mode_t pmode5_reg;
    logic [30:0] life5_reg;
    logic [30:0] total5_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v5_reg <= 1'b0;
        end
        else if (en) begin
            v5_reg <= v4_reg;
        end
    end
    always_ff @(posedge clk) begin
        if (en) begin
            life5_reg <= life4_reg[30:0];
            total5_reg <= p4_reg.life_total;
            r5_reg.atlas_frame <= '0;
            r5_reg.atlas_next_frame <= '0;
            r5_reg.frame_blend <= '0;
            if (p4_reg.life_left[31]) begin
                r5_reg.alive <= 1'b0;
                r5_reg.new_position_x <= p4_reg.position_x;
                r5_reg.new_position_y <= p4_reg.position_y;
                r5_reg.new_position_z <= p4_reg.position_z;
                r5_reg.new_velocity_y <= p4_reg.velocity_y;
                r5_reg.new_life_left <= p4_reg.life_left;
                r5_reg.camera_distance_sq <= '0;
                pmode5_reg <= PM_DEAD;
            end
            else begin
                r5_reg.alive <= 1'b1;
                r5_reg.new_position_x <= nx4_reg;
                r5_reg.new_position_y <= sat32(68'(p4_reg.position_y)
                                              + 68'(my_reg >>> FractionBits));
                r5_reg.new_position_z <= nz4_reg;
                r5_reg.new_velocity_y <= nvy4_reg;
                r5_reg.new_life_left <= life4_reg[31:0];
                r5_reg.camera_distance_sq <= life4_reg[32]
                    ? -(32'sd1 <<< FractionBits) : dist4_reg;
                if (life4_reg[32] || life4_reg == 33'sd0 || p4_reg.life_total == 31'd0) begin
                    pmode5_reg <= PM_ZERO;
                end
                else if (life4_reg[30:0] >= p4_reg.life_total) begin
                    pmode5_reg <= PM_FULL;
                end
                else begin
                    pmode5_reg <= PM_DIV;
                end
            end
        end
    end

    // Stage 6: life times frames; the divider takes it shifted left by 16.
    logic [39:0] num_prod_reg;
    logic [30:0] total6_reg;
    prog_mode_t pmode6_reg;
    particle_out_t r6_reg;
    logic v6_reg;
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v6_reg <= 1'b0;
        end
        else if (en) begin
            v6_reg <= v5_reg;
        end
    end
    always_ff @(posedge clk) begin
        if (en) begin
            num_prod_reg <= life5_reg * frames_reg;
            total6_reg <= total5_reg;
            pmode6_reg <= pmode5_reg;
            r6_reg <= r5_reg;
        end
    end

    logic [ProgBits-1:0] q_out;
    logic div_v;
    logic [SideBits-1:0] div_side;
    prog_mode_t pm_out;
    particle_out_t r_out;

    pls_divider #(
        .SideBits (SideBits)
    ) u_div (
        .clk (clk),
        .rst_n (rst_n),
        .en (en),
        .in_valid (v6_reg),
        .in_num ({num_prod_reg, 16'd0}),
        .in_den (total6_reg),
        .in_side ({pmode6_reg, r6_reg}),
        .out_valid (div_v),
        .out_quot (q_out),
        .out_side (div_side)
    );
    assign pm_out = prog_mode_t'(div_side[SideBits-1 -: 2]);
    assign r_out = div_side[SideBits-3:0];

    logic [ProgBits-1:0] prog;
    logic [8:0] frm;
    always_comb begin
        unique case (pm_out)
            PM_FULL: prog = {frames_reg, 16'd0};
            PM_DIV: prog = q_out;
            default: prog = '0;
        endcase
        frm = prog[24:16];
        out_next = r_out;
        if (pm_out != PM_DEAD) begin
            out_next.atlas_frame = frm;
            out_next.atlas_next_frame = (frm < frames_reg - 9'd1) ? frm + 9'd1 : frm;
            out_next.frame_blend = prog[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_v_reg <= 1'b0;
        end
        else if (en) begin
            out_v_reg <= div_v;
        end
    end
    always_ff @(posedge clk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign out_ch.valid = out_v_reg;
    assign out_ch.data = out_reg;
endmodule

@@ rtl/core/pls_divider.sv @@
// Pipelined restoring divider for the atlas progression, one quotient bit
// per stage, moving under a shared enable. Depends on pls_pkg.
module pls_divider
    import pls_pkg::*;
#(
    parameter int SideBits = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic [DivNumBits-1:0] in_num,
    input  logic [30:0] in_den,
    input  logic [SideBits-1:0] in_side,
    output logic out_valid,
    output logic [ProgBits-1:0] out_quot,
    output logic [SideBits-1:0] out_side
);
    logic [ProgBits:0] v_reg;
    logic [ProgBits-1:0] low_reg [ProgBits+1];
    logic [ProgBits-1:0] quot_reg [ProgBits+1];
    logic [31:0] rem_reg [ProgBits+1];
    logic [30:0] den_reg [ProgBits+1];
    logic [SideBits-1:0] side_reg [ProgBits+1];
    logic [32:0] trial [ProgBits];
    logic [32:0] diff [ProgBits];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v_reg <= '0;
        end
        else if (en) begin
            v_reg <= {v_reg[ProgBits-1:0], in_valid};
        end
    end

    always_comb begin
        for (int s = 0; s < ProgBits; s++) begin
            trial[s] = {rem_reg[s], low_reg[s][ProgBits-1-s]};
            diff[s] = trial[s] - {2'b00, den_reg[s]};
        end
    end

    // The numerator's top 31 bits are below the divisor, so they seed the
    // remainder and only the low quotient bits need a stage each.
    always_ff @(posedge clk) begin
        if (en) begin
            low_reg[0] <= in_num[ProgBits-1:0];
            rem_reg[0] <= {1'b0, in_num[DivNumBits-1:ProgBits]};
            den_reg[0] <= in_den;
            quot_reg[0] <= '0;
            side_reg[0] <= in_side;
            for (int s = 0; s < ProgBits; s++) begin
                low_reg[s+1] <= low_reg[s];
                den_reg[s+1] <= den_reg[s];
                side_reg[s+1] <= side_reg[s];
                if (!diff[s][32]) begin
                    rem_reg[s+1] <= diff[s][31:0];
                    quot_reg[s+1] <= quot_reg[s] | (ProgBits'(1) << (ProgBits-1-s));
                end
                else begin
                    rem_reg[s+1] <= trial[s][31:0];
                    quot_reg[s+1] <= quot_reg[s];
                end
            end
        end
    end

    assign out_valid = v_reg[ProgBits];
    assign out_quot = quot_reg[ProgBits];
    assign out_side = side_reg[ProgBits];
endmodule
